// File: sv/jlpd_pkg.sv
// ---------------------------------------------------------------------------
// jlpd_pkg: shared types and constants of the joystick LED PWM dimmer
// Register map, reset values, LED count and the structs passed between units.
// ---------------------------------------------------------------------------
package jlpd_pkg;

  // Number of LED channels in use (2 or 3); three slots always exist on the
  // ports, and a slot beyond the count stays dark.
  localparam int unsigned NumLeds  = 3;
  localparam int unsigned LedSlots = 3;

  localparam int unsigned DutyW  = 8;
  localparam int unsigned PhaseW = 8;
  localparam int unsigned SelW   = 2;

  localparam logic [SelW-1:0] LastLed = SelW'(NumLeds - 1);

  // Register reset values
  localparam logic [7:0] PeriodRst  = 8'd50;
  localparam logic [7:0] StepRst    = 8'd10;
  localparam logic [7:0] MaxDutyRst = 8'd40;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    RegPwmPeriod = 2'd0,
    RegLevelStep = 2'd1,
    RegMaxDuty   = 2'd2,
    RegUnused    = 2'd3
  } reg_idx_e;

  localparam int unsigned AddrW = 4;

  typedef struct packed {
    logic btn_right;
    logic btn_left;
    logic btn_down;
    logic btn_up;
  } joy_t;

  typedef struct packed {
    logic [7:0] pwm_period;
    logic [7:0] level_step;
    logic [7:0] max_duty;
  } cfg_t;

  typedef logic [LedSlots-1:0][DutyW-1:0] duty_arr_t;

endpackage

// File: sv/jlpd_ctrl.sv
// ---------------------------------------------------------------------------
// jlpd_ctrl: joystick control of LED duty and selection
// Holds the duty of each LED, the selected LED and the arm flag.
// ---------------------------------------------------------------------------
module jlpd_ctrl
  import jlpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  joy_t              joy_i,
  input  cfg_t              cfg_i,
  output duty_arr_t         duty_o,   // duty after this tick
  output logic [SelW-1:0]   sel_o,    // selection after this tick
  output logic [DutyW-1:0]  sel_duty_o
);

  duty_arr_t         duty_q, duty_d;
  logic [SelW-1:0]   sel_q, sel_d;
  logic              armed_q, armed_d;
  logic [DutyW-1:0]  cur_duty;
  logic [DutyW:0]    sum;
  logic [DutyW-1:0]  diff;
  logic [SelW:0]     sel_inc;
  logic              any_dir;

  assign any_dir  = joy_i.btn_up | joy_i.btn_down | joy_i.btn_left | joy_i.btn_right;
  assign cur_duty = duty_q[sel_q];
  assign sum      = {1'b0, cur_duty} + {1'b0, cfg_i.level_step};
  assign diff     = cur_duty - cfg_i.level_step;
  assign sel_inc  = {1'b0, sel_q} + {{SelW{1'b0}}, 1'b1};

  always_comb begin
    duty_d  = duty_q;
    sel_d   = sel_q;
    armed_d = armed_q;
    if (armed_q && any_dir) begin
      armed_d = 1'b0;
      if (joy_i.btn_up) begin
        // raise, saturate at the ceiling
        if (cur_duty < cfg_i.max_duty) begin
          duty_d[sel_q] = (sum > {1'b0, cfg_i.max_duty}) ? cfg_i.max_duty : sum[DutyW-1:0];
        end
      end else if (joy_i.btn_down) begin
        // lower, never below one step
        if (cur_duty > cfg_i.level_step) begin
          duty_d[sel_q] = (diff < cfg_i.level_step) ? cfg_i.level_step : diff;
        end
      end else if (joy_i.btn_left) begin
        sel_d = (sel_q == '0) ? LastLed : sel_q - SelW'(1);
      end else begin
        sel_d = (sel_inc >= (SelW+1)'(NumLeds)) ? '0 : sel_inc[SelW-1:0];
      end
    end else if (!any_dir) begin
      armed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= {LedSlots{StepRst}};
      sel_q   <= '0;
      armed_q <= 1'b1;
    end else if (step_i) begin
      duty_q  <= duty_d;
      sel_q   <= sel_d;
      armed_q <= armed_d;
    end
  end

  assign duty_o     = duty_d;
  assign sel_o      = sel_d;
  assign sel_duty_o = duty_d[sel_d];

endmodule

// File: sv/jlpd_pwm.sv
// ---------------------------------------------------------------------------
// jlpd_pwm: phase counter and LED switching
// Switches each LED on at phase zero and off where the phase meets its duty.
// ---------------------------------------------------------------------------
module jlpd_pwm
  import jlpd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           period_i,
  input  duty_arr_t            duty_i,
  output logic [LedSlots-1:0]  led_o    // levels after this tick
);

  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [PhaseW:0]     phase_inc;
  logic [LedSlots-1:0] led_q, led_d;

  assign phase_inc = {1'b0, phase_q} + {{PhaseW{1'b0}}, 1'b1};
  assign phase_d   = (phase_inc >= {1'b0, period_i}) ? '0 : phase_inc[PhaseW-1:0];

  always_comb begin
    for (int i = 0; i < LedSlots; i++) begin
      if (i < NumLeds) begin
        led_d[i] = led_q[i];
        if (phase_q == '0) begin
          led_d[i] = 1'b1;
        end
        // switch-off wins over switch-on
        if (duty_i[i] == phase_q) begin
          led_d[i] = 1'b0;
        end
      end else begin
        led_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      led_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      led_q   <= led_d;
    end
  end

  assign led_o = led_d;

endmodule

// File: sv/joystick_led_pwm_dimmer_unit.sv
// ---------------------------------------------------------------------------
// joystick_led_pwm_dimmer_unit: three-channel PWM LED dimmer with joystick
// Top level: configuration registers, tick processing and result register.
// ---------------------------------------------------------------------------
// Usage
//   Each transfer on the s_axis side is one PWM tick carrying the four
//   joystick directions. Each tick yields exactly one result transfer on the
//   m_axis side: the three LED levels after the tick, the selected LED and
//   its duty.
//   Latency: the result is valid in the cycle after the tick transfer.
//   Throughput: one tick per cycle while m_axis_tready is high; all the work
//   of a tick is one pass of shallow logic into the state and result registers.
//   Backpressure: the result register is a single stage; s_axis_tready is
//   high while that stage is empty or being drained this cycle, so a stalled
//   receiver holds off at most one further tick.
//   Configuration: APB writes at byte addresses 0 (pwm_period), 4
//   (level_step) and 8 (max_duty); issue them only while idle.
//   Reset: phase and selection go to zero, every duty to 10, the block is
//   armed, all LEDs dark, registers to 50/10/40 and the result stage empty.
// ---------------------------------------------------------------------------
module joystick_led_pwm_dimmer_unit
  import jlpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // tick input
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [0] up [1] down [2] left [3] right
  // result output
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] led_zero [1] led_one [2] led_two
                                           // [4:3] selected_led [12:5] selected_duty
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t                cfg_q, cfg_d;
  reg_idx_e            reg_idx;
  logic                cfg_wr;
  logic                step;
  joy_t                joy;
  duty_arr_t           duty_next;
  logic [SelW-1:0]     sel_next;
  logic [DutyW-1:0]    sel_duty;
  logic [LedSlots-1:0] led_next;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         out_data_q, out_data_d;

  // ---- configuration port ----
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        RegPwmPeriod: cfg_d.pwm_period = pwdata[7:0];
        RegLevelStep: cfg_d.level_step = pwdata[7:0];
        RegMaxDuty:   cfg_d.max_duty   = pwdata[7:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPwmPeriod: prdata = {24'd0, cfg_q.pwm_period};
      RegLevelStep: prdata = {24'd0, cfg_q.level_step};
      RegMaxDuty:   prdata = {24'd0, cfg_q.max_duty};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period <= PeriodRst;
      cfg_q.level_step <= StepRst;
      cfg_q.max_duty   <= MaxDutyRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---- tick intake: accept while the result stage is empty or draining ----
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign step          = s_axis_tvalid & s_axis_tready;

  assign joy.btn_up    = s_axis_tdata[0];
  assign joy.btn_down  = s_axis_tdata[1];
  assign joy.btn_left  = s_axis_tdata[2];
  assign joy.btn_right = s_axis_tdata[3];

  jlpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .joy_i      (joy),
    .cfg_i      (cfg_q),
    .duty_o     (duty_next),
    .sel_o      (sel_next),
    .sel_duty_o (sel_duty)
  );

  jlpd_pwm u_pwm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .period_i (cfg_q.pwm_period),
    .duty_i   (duty_next),
    .led_o    (led_next)
  );

  // ---- result register: load on a tick, drop once transferred ----
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'd0, sel_duty, sel_next, led_next[2], led_next[1], led_next[0]};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  // Intake only stalls while a result waits on a stalled receiver
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("tick intake stalled without a pending result");

  // Every accepted tick yields a result in the next cycle
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // The reported selection always names an existing LED
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:3] <= LastLed))
    else $error("selected LED out of range");

  // A result is held until it is transferred
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result lost or changed");
`endif

endmodule

// File: tb/sv/joystick_led_pwm_dimmer_unit_tb.sv
// ---------------------------------------------------------------------------
// joystick_led_pwm_dimmer_unit_tb: self-checking bench of the LED PWM dimmer
// Streams joystick ticks into the block and checks each result transfer
// against a cycle-free shadow of the dimmer state. The register settings
// change between phases over APB, with a readback of every written register.
// ---------------------------------------------------------------------------
module joystick_led_pwm_dimmer_unit_tb;
  import jlpd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffLen = 150;

  // Result as it sits in m_axis_tdata[12:0], led_zero in bit 0
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [SelW-1:0]  sel;
    logic             led2;
    logic             led1;
    logic             led0;
  } led_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  joystick_led_pwm_dimmer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // Ticks waiting to be offered, and LED results still owed by the block
  joy_t        tick_q[$];
  led_result_t led_result_q[$];

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b1;

  // Shadow copy of the register settings and of the dimmer state
  logic [7:0]       cfg_period;
  logic [7:0]       cfg_step;
  logic [7:0]       cfg_max;
  logic [PhaseW-1:0] shadow_phase;
  logic [DutyW-1:0] shadow_duty [LedSlots];
  logic [SelW-1:0]  shadow_sel;
  logic             shadow_armed;
  logic             shadow_led [LedSlots];

  // -------------------------------------------------------------------------
  // Shadow dimmer: one call per accepted tick, returns the owed result
  // -------------------------------------------------------------------------
  function automatic led_result_t next_led_result(joy_t j);
    int unsigned s;
    int unsigned d;
    int unsigned n;
    led_result_t r;
    // Fall back to LED zero if the selection ever points past the last LED
    s = (shadow_sel < NumLeds) ? shadow_sel : 0;
    d = shadow_duty[s];
    shadow_sel = SelW'(s);
    // Joystick first: one action per armed tick, up > down > left > right
    if (shadow_armed && (j != '0)) begin
      if (j.btn_up) begin
        if (d < cfg_max) begin
          n = d + cfg_step;
          shadow_duty[s] = (n > cfg_max) ? cfg_max : 8'(n);
        end
      end else if (j.btn_down) begin
        // Never drop below one step
        if (d > cfg_step) begin
          n = d - cfg_step;
          shadow_duty[s] = (n < cfg_step) ? cfg_step : 8'(n);
        end
      end else if (j.btn_left) begin
        shadow_sel = (s == 0) ? SelW'(NumLeds - 1) : SelW'(s - 1);
      end else begin
        shadow_sel = (s + 1 >= NumLeds) ? '0 : SelW'(s + 1);
      end
      shadow_armed = 1'b0;
    end else if (j == '0) begin
      shadow_armed = 1'b1;
    end
    // LEDs next, on the new duty: switch-off wins over switch-on at phase 0,
    // and a duty at or past the period keeps the LED lit
    for (int i = 0; i < LedSlots; i++) begin
      if (i >= NumLeds) begin
        shadow_led[i] = 1'b0;
      end else begin
        if (shadow_phase == 0) shadow_led[i] = 1'b1;
        if (shadow_duty[i] == shadow_phase) shadow_led[i] = 1'b0;
      end
    end
    // Phase last; it also falls back to zero if a new period leaves it out of range
    if (int'(shadow_phase) + 1 >= int'(cfg_period)) shadow_phase = '0;
    else shadow_phase = shadow_phase + 1'b1;
    s = (shadow_sel < NumLeds) ? shadow_sel : 0;
    r.led0 = shadow_led[0];
    r.led1 = shadow_led[1];
    r.led2 = shadow_led[2];
    r.sel  = SelW'(s);
    r.duty = shadow_duty[s];
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, what, want, got);
      err_count++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: offer queued ticks, with a random gap after each transfer
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : tick_driver
    int unsigned tx_gap;
    logic        nxt_valid;
    joy_t        nxt_joy;
    if (!rst_ni) begin
      tx_gap = 0;
      s_axis_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_joy   = joy_t'(s_axis_tdata[3:0]);
      if (s_axis_tvalid && s_axis_tready) begin
        // Transfer taken: work out what the block owes for it
        led_result_q.push_back(next_led_result(joy_t'(s_axis_tdata[3:0])));
        nxt_valid = 1'b0;
        tx_gap = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (tick_q.size() != 0) begin
          nxt_joy   = tick_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      // Single update per edge, so a back-to-back transfer keeps tvalid high
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= {4'b0000, nxt_joy};
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: check every result transfer and pace tready; hold off once for
  // a long stretch mid-run so the result stage fills and stalls the input
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    int unsigned rx_gap;
    int unsigned rx_hold;
    int unsigned rx_count;
    bit          hold_done;
    led_result_t got;
    led_result_t want;
    if (!rst_ni) begin
      rx_gap    = 0;
      rx_hold   = 0;
      rx_count  = 0;
      hold_done = 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = led_result_t'(m_axis_tdata[12:0]);
        if (led_result_q.size() == 0) begin
          $display("%0t: result with nothing owed, expected none, actual %0h",
                   $time, m_axis_tdata);
          err_count++;
        end else begin
          want = led_result_q.pop_front();
          check_field("led_zero", want.led0, got.led0);
          check_field("led_one", want.led1, got.led1);
          check_field("led_two", want.led2, got.led2);
          check_field("selected_led", want.sel, got.sel);
          check_field("selected_duty", want.duty, got.duty);
        end
        rx_count++;
        rx_gap = idle_on ? $urandom_range(0, 6) : 0;
        if (!hold_done && rx_count >= 300 && tick_q.size() > 20) begin
          rx_hold   = HoldOffLen;
          hold_done = 1'b1;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic joy_t mk_joy(bit up, bit down, bit left, bit right);
    return joy_t'({right, left, down, up});
  endfunction

  // Hold until every queued tick is taken and every result has arrived
  task automatic wait_drained();
    while (tick_q.size() != 0 || s_axis_tvalid || led_result_q.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write one register, update the shadow setting, then read it back
  task automatic apb_write_reg(reg_idx_e idx, logic [7:0] value);
    logic [AddrW-1:0] addr;
    logic [31:0]      rd;
    addr = AddrW'(idx) << 2;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegPwmPeriod: cfg_period = value;
      RegLevelStep: cfg_step   = value;
      RegMaxDuty:   cfg_max    = value;
      default: ;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("prdata", value, rd[7:0]);
  endtask

  // Mostly press-and-release sequences with random content, some noise
  task automatic push_random_ticks(int unsigned count);
    int unsigned pushed;
    int unsigned len;
    joy_t        j;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) == 0) j = joy_t'(4'($urandom_range(1, 15)));
        else j = joy_t'(4'b0001 << $urandom_range(0, 3));
        len = $urandom_range(1, 3);
        repeat (len) begin
          tick_q.push_back(j);
          pushed++;
        end
        len = $urandom_range(1, 3);
        repeat (len) begin
          tick_q.push_back('0);
          pushed++;
        end
      end else begin
        tick_q.push_back(joy_t'(4'($urandom_range(0, 15))));
        pushed++;
      end
    end
  endtask

  // Drain, reprogram all three registers, then stream a batch of ticks
  task automatic run_phase(logic [7:0] period, logic [7:0] step, logic [7:0] maxd, bit idle);
    wait_drained();
    apb_write_reg(RegPwmPeriod, period);
    apb_write_reg(RegLevelStep, step);
    apb_write_reg(RegMaxDuty, maxd);
    idle_on = idle;
    push_random_ticks(145);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    cfg_period   = PeriodRst;
    cfg_step     = StepRst;
    cfg_max      = MaxDutyRst;
    shadow_phase = '0;
    shadow_sel   = '0;
    shadow_armed = 1'b1;
    for (int i = 0; i < LedSlots; i++) begin
      shadow_duty[i] = StepRst;
      shadow_led[i]  = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks on the reset settings: raise to the ceiling, hold a
    // button (no repeat while disarmed), saturate, lower, priority between
    // simultaneous directions and selection wrap both ways
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(1, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(1, 0, 0, 0));
    tick_q.push_back(mk_joy(1, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(1, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(1, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 1, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(1, 1, 1, 1));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 1, 0));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 0, 1));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 0, 1));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 0, 1, 1));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 1, 1, 1));
    tick_q.push_back(mk_joy(0, 0, 0, 0));
    tick_q.push_back(mk_joy(0, 1, 0, 0));

    // Shortest period with duties past it, coarsest and finest steps,
    // duties stuck above a lowered ceiling, ceiling below one step
    run_phase(8'd2, 8'd1, 8'd255, 1'b1);
    run_phase(8'd255, 8'd255, 8'd255, 1'b1);
    run_phase(8'd255, 8'd1, 8'd1, 1'b0);
    run_phase(8'd20, 8'd5, 8'd17, 1'b1);
    run_phase(8'd100, 8'd30, 8'd20, 1'b1);
    run_phase(8'($urandom_range(2, 30)), 8'($urandom_range(1, 8)),
              8'($urandom_range(1, 40)), 1'b0);
    run_phase(8'($urandom_range(2, 255)), 8'($urandom_range(1, 255)),
              8'($urandom_range(1, 255)), 1'b1);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: joystick_led_pwm_dimmer_unit.f
sv/jlpd_pkg.sv
sv/jlpd_ctrl.sv
sv/jlpd_pwm.sv
sv/joystick_led_pwm_dimmer_unit.sv
tb/sv/joystick_led_pwm_dimmer_unit_tb.sv
